/* sv/vq_block_codebook_expander_core_defines.svh */
// Assertion macros for the codebook expander core.
`ifndef VQ_BLOCK_CODEBOOK_EXPANDER_CORE_DEFINES_SVH
`define VQ_BLOCK_CODEBOOK_EXPANDER_CORE_DEFINES_SVH
`ifndef SYNTH
`define VQBCE_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vqbce assertion failed");
`define VQBCE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vqbce assertion failed");
`else
`define VQBCE_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define VQBCE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

/* sv/vqbce_pkg.sv */
// Shared types and constants of the codebook expander core.
package vqbce_pkg;

   localparam int CODEBOOK_ENTRIES = 4096;
   localparam int WORD_W           = 32;
   localparam int CB_WORDS         = CODEBOOK_ENTRIES * 4;
   localparam int CB_BYTES         = CODEBOOK_ENTRIES * 16;
   localparam int CB_AW            = $clog2(CB_WORDS);
   localparam int KIND_W           = 3;
   localparam int OFFSET_W         = 17;
   localparam int PARTS_W          = 4;
   localparam int HEIGHT_W         = 3;
   localparam int CSR_INDEX_W      = 1;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX      = '1;
   localparam logic [PARTS_W-1:0]  PARTS_MAX       = '1;
   localparam logic [PARTS_W-1:0]  PARTS_SWAP      = 4'd8;
   localparam logic [7:0]          FILL_MARK_SHORT = 8'h0f;
   localparam logic [7:0]          FILL_MARK_TALL  = 8'hff;
   localparam logic [7:0]          LINE_MAX        = 8'hff;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN      = 3'd2;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX      = 3'd4;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 3'd4;
   localparam logic [7:0]          BPR_RESET       = 8'd80;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACT_WRITE  = 3'd0,
      KIND_STG_APPEND = 3'd1,
      KIND_STG_END    = 3'd2,
      KIND_EXPAND     = 3'd3,
      KIND_FRAME_END  = 3'd4
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_HEIGHT   = 1'b0,
      CSR_BLOCKS_PER_ROW = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACT_WRITE,
      ST_STG_WRITE,
      ST_EXPAND,
      ST_COPY
   } state_type;

endpackage

/* sv/vqbce_ram.sv */
// Generic simple dual-port RAM with registered read.
module vqbce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/vq_block_codebook_expander_core.sv */
// Top level of the vector-quantization block expander with active and staged codebooks.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+------------------------------
//   request  | start, busy, req_*                     | beat taken on start & !busy
//   response | rsp_strobe, rsp_*                      | no stall
//   csr      | csr_valid, csr_ready, csr_index, wdata | beat taken on valid & ready
//
// Codebook byte writes and staged appends read the word, merge the byte and write it back.
// End of staged part, and end of frame without a swap, are handled in the idle state.
// Block expansion streams one row per cycle from the codebook read port.
// End of frame with a swap copies the staged codebook word by word into the active codebook.
// Reset clears control state only; no clearing pass.
// The response side cannot stall; rows leave back to back on rsp_strobe.
`include "vq_block_codebook_expander_core_defines.svh"

module vq_block_codebook_expander_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [vqbce_pkg::KIND_W-1:0]      req_kind,
   input  logic [15:0]                       req_address,
   input  logic [7:0]                        req_data_byte,
   input  logic [7:0]                        req_low_index,
   input  logic [7:0]                        req_high_index,
   output logic                              rsp_strobe,
   output logic [7:0]                        rsp_pixel_zero,
   output logic [7:0]                        rsp_pixel_one,
   output logic [7:0]                        rsp_pixel_two,
   output logic [7:0]                        rsp_pixel_three,
   output logic [7:0]                        rsp_block_column,
   output logic [7:0]                        rsp_block_line,
   output logic [1:0]                        rsp_row_in_block,
   output logic                              rsp_last_row,
   output logic                              rsp_index_error,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vqbce_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                        csr_wdata
);

   import vqbce_pkg::*;

   state_type             state_ff, state_in;
   logic [1:0]            row_ff, row_in;
   logic [HEIGHT_W-1:0]   height_ff, height_in;
   logic                  fill_ff, fill_in;
   logic                  err_ff, err_in;
   logic [7:0]            fill_byte_ff, fill_byte_in;
   logic [7:0]            col_out_ff, col_out_in;
   logic [7:0]            line_out_ff, line_out_in;
   logic [CB_AW-1:0]      base_ff, base_in;
   logic [CB_AW-1:0]      wr_word_ff, wr_word_in;
   logic [1:0]            wr_lane_ff, wr_lane_in;
   logic [7:0]            wr_byte_ff, wr_byte_in;
   logic                  wr_ok_ff, wr_ok_in;
   logic [OFFSET_W-1:0]   staged_offset_ff, staged_offset_in;
   logic [PARTS_W-1:0]    staged_parts_ff, staged_parts_in;
   logic [7:0]            column_ff, column_in;
   logic [7:0]            line_ff, line_in;
   logic [HEIGHT_W-1:0]   block_height_ff, block_height_in;
   logic [7:0]            blocks_per_row_ff, blocks_per_row_in;
   logic [CB_AW:0]        copy_cnt_ff, copy_cnt_in;

   logic                  act_re, act_we, stg_re, stg_we;
   logic [CB_AW-1:0]      act_raddr, act_waddr, stg_raddr, stg_waddr;
   logic [WORD_W-1:0]     act_wdata, stg_wdata, act_rdata, stg_rdata;

   logic [HEIGHT_W-1:0]   height_cur;
   logic [7:0]            marker_cur;
   logic [15:0]           index_cur;
   logic                  fill_cur;
   logic                  err_cur;
   logic [18:0]           base_full;
   logic [8:0]            col_limit;
   logic [8:0]            col_next;
   logic                  last_row;

   function automatic logic [WORD_W-1:0] merge_byte(input logic [WORD_W-1:0] cur,
                                                    input logic [1:0] lane,
                                                    input logic [7:0] value);
      logic [WORD_W-1:0] result;
      result = cur;
      result[8*lane +: 8] = value;
      return result;
   endfunction

   vqbce_ram #(.WIDTH(WORD_W), .DEPTH(CB_WORDS)) u_active (
      .clock   (clock),
      .wr_en   (act_we),
      .wr_addr (act_waddr),
      .wr_data (act_wdata),
      .rd_en   (act_re),
      .rd_addr (act_raddr),
      .rd_data (act_rdata)
   );

   vqbce_ram #(.WIDTH(WORD_W), .DEPTH(CB_WORDS)) u_staged (
      .clock   (clock),
      .wr_en   (stg_we),
      .wr_addr (stg_waddr),
      .wr_data (stg_wdata),
      .rd_en   (stg_re),
      .rd_addr (stg_raddr),
      .rd_data (stg_rdata)
   );

   always_comb begin
      if (block_height_ff < HEIGHT_MIN) begin
         height_cur = HEIGHT_MIN;
      end else if (block_height_ff > HEIGHT_MAX) begin
         height_cur = HEIGHT_MAX;
      end else begin
         height_cur = block_height_ff;
      end
   end

   assign marker_cur = (height_cur == HEIGHT_MIN) ? FILL_MARK_SHORT : FILL_MARK_TALL;
   assign index_cur  = {req_high_index, req_low_index};
   assign fill_cur   = (req_high_index == marker_cur);
   assign err_cur    = !fill_cur && (32'(index_cur) >= 32'(CODEBOOK_ENTRIES));
   assign base_full  = 19'(index_cur) * 19'(height_cur);
   assign col_limit  = (blocks_per_row_ff == 8'd0) ? 9'd256 : {1'b0, blocks_per_row_ff};
   assign col_next   = 9'(column_ff) + 9'd1;
   assign last_row   = (row_ff == 2'(height_ff - 3'd1));

   always_comb begin
      state_in          = state_ff;
      row_in            = row_ff;
      height_in         = height_ff;
      fill_in           = fill_ff;
      err_in            = err_ff;
      fill_byte_in      = fill_byte_ff;
      col_out_in        = col_out_ff;
      line_out_in       = line_out_ff;
      base_in           = base_ff;
      wr_word_in        = wr_word_ff;
      wr_lane_in        = wr_lane_ff;
      wr_byte_in        = wr_byte_ff;
      wr_ok_in          = wr_ok_ff;
      staged_offset_in  = staged_offset_ff;
      staged_parts_in   = staged_parts_ff;
      column_in         = column_ff;
      line_in           = line_ff;
      block_height_in   = block_height_ff;
      blocks_per_row_in = blocks_per_row_ff;
      copy_cnt_in       = copy_cnt_ff;
      act_re            = 1'b0;
      act_raddr         = '0;
      act_we            = 1'b0;
      act_waddr         = '0;
      act_wdata         = '0;
      stg_re            = 1'b0;
      stg_raddr         = '0;
      stg_we            = 1'b0;
      stg_waddr         = '0;
      stg_wdata         = '0;
      rsp_strobe        = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLOCK_HEIGHT:   block_height_in   = csr_wdata[HEIGHT_W-1:0];
            CSR_BLOCKS_PER_ROW: blocks_per_row_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_ACT_WRITE: begin
                     act_re     = 1'b1;
                     act_raddr  = CB_AW'(req_address[15:2]);
                     wr_word_in = CB_AW'(req_address[15:2]);
                     wr_lane_in = req_address[1:0];
                     wr_byte_in = req_data_byte;
                     wr_ok_in   = (32'(req_address) < 32'(CB_BYTES));
                     state_in   = ST_ACT_WRITE;
                  end
                  KIND_STG_APPEND: begin
                     stg_re     = 1'b1;
                     stg_raddr  = CB_AW'(staged_offset_ff[OFFSET_W-1:2]);
                     wr_word_in = CB_AW'(staged_offset_ff[OFFSET_W-1:2]);
                     wr_lane_in = staged_offset_ff[1:0];
                     wr_byte_in = req_data_byte;
                     wr_ok_in   = (32'(staged_offset_ff) < 32'(CB_BYTES));
                     if (staged_offset_ff != OFFSET_MAX) begin
                        staged_offset_in = staged_offset_ff + 1'b1;
                     end
                     state_in   = ST_STG_WRITE;
                  end
                  KIND_STG_END: begin
                     if (staged_parts_ff != PARTS_MAX) begin
                        staged_parts_in = staged_parts_ff + 1'b1;
                     end
                  end
                  KIND_EXPAND: begin
                     act_re       = 1'b1;
                     act_raddr    = CB_AW'(base_full);
                     base_in      = CB_AW'(base_full);
                     row_in       = 2'd0;
                     height_in    = height_cur;
                     fill_in      = fill_cur;
                     err_in       = err_cur;
                     fill_byte_in = req_low_index;
                     col_out_in   = column_ff;
                     line_out_in  = line_ff;
                     if (col_next >= col_limit) begin
                        column_in = 8'd0;
                        if (line_ff != LINE_MAX) begin
                           line_in = line_ff + 8'd1;
                        end
                     end else begin
                        column_in = col_next[7:0];
                     end
                     state_in     = ST_EXPAND;
                  end
                  KIND_FRAME_END: begin
                     column_in = 8'd0;
                     line_in   = 8'd0;
                     if (staged_parts_ff >= PARTS_SWAP) begin
                        staged_offset_in = '0;
                        staged_parts_in  = '0;
                        copy_cnt_in      = '0;
                        state_in         = ST_COPY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ACT_WRITE: begin
            act_we    = wr_ok_ff;
            act_waddr = wr_word_ff;
            act_wdata = merge_byte(act_rdata, wr_lane_ff, wr_byte_ff);
            state_in  = ST_IDLE;
         end
         ST_STG_WRITE: begin
            stg_we    = wr_ok_ff;
            stg_waddr = wr_word_ff;
            stg_wdata = merge_byte(stg_rdata, wr_lane_ff, wr_byte_ff);
            state_in  = ST_IDLE;
         end
         ST_EXPAND: begin
            rsp_strobe = 1'b1;
            act_re     = 1'b1;
            act_raddr  = CB_AW'(base_ff + CB_AW'(row_ff) + CB_AW'(1));
            row_in     = row_ff + 2'd1;
            if (last_row) begin
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            if (copy_cnt_ff < (CB_AW+1)'(CB_WORDS)) begin
               stg_re    = 1'b1;
               stg_raddr = copy_cnt_ff[CB_AW-1:0];
            end
            if (copy_cnt_ff != '0) begin
               act_we    = 1'b1;
               act_waddr = CB_AW'(copy_cnt_ff - 1'b1);
               act_wdata = stg_rdata;
            end
            copy_cnt_in = copy_cnt_ff + 1'b1;
            if (copy_cnt_ff == (CB_AW+1)'(CB_WORDS)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         staged_offset_ff  <= '0;
         staged_parts_ff   <= '0;
         column_ff         <= 8'd0;
         line_ff           <= 8'd0;
         block_height_ff   <= HEIGHT_RESET;
         blocks_per_row_ff <= BPR_RESET;
      end else begin
         state_ff          <= state_in;
         staged_offset_ff  <= staged_offset_in;
         staged_parts_ff   <= staged_parts_in;
         column_ff         <= column_in;
         line_ff           <= line_in;
         block_height_ff   <= block_height_in;
         blocks_per_row_ff <= blocks_per_row_in;
      end
      row_ff       <= row_in;
      height_ff    <= height_in;
      fill_ff      <= fill_in;
      err_ff       <= err_in;
      fill_byte_ff <= fill_byte_in;
      col_out_ff   <= col_out_in;
      line_out_ff  <= line_out_in;
      base_ff      <= base_in;
      wr_word_ff   <= wr_word_in;
      wr_lane_ff   <= wr_lane_in;
      wr_byte_ff   <= wr_byte_in;
      wr_ok_ff     <= wr_ok_in;
      copy_cnt_ff  <= copy_cnt_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_pixel_zero   = fill_ff ? fill_byte_ff : (err_ff ? 8'd0 : act_rdata[7:0]);
   assign rsp_pixel_one    = fill_ff ? fill_byte_ff : (err_ff ? 8'd0 : act_rdata[15:8]);
   assign rsp_pixel_two    = fill_ff ? fill_byte_ff : (err_ff ? 8'd0 : act_rdata[23:16]);
   assign rsp_pixel_three  = fill_ff ? fill_byte_ff : (err_ff ? 8'd0 : act_rdata[31:24]);
   assign rsp_block_column = col_out_ff;
   assign rsp_block_line   = line_out_ff;
   assign rsp_row_in_block = row_ff;
   assign rsp_last_row     = last_row;
   assign rsp_index_error  = err_ff;

   `VQBCE_ASSERT_NEXT(a_expand_starts_row0, clock, reset, start && !busy && req_kind == KIND_EXPAND, rsp_strobe && rsp_row_in_block == 2'd0)
   `VQBCE_ASSERT_NEXT(a_rows_advance, clock, reset, rsp_strobe && !rsp_last_row, rsp_strobe && rsp_row_in_block == $past(rsp_row_in_block) + 2'd1)
   `VQBCE_ASSERT_NEXT(a_block_ends_idle, clock, reset, rsp_strobe && rsp_last_row, !rsp_strobe && !busy)
   `VQBCE_ASSERT_IMPLY(a_error_zero_pixels, clock, reset, rsp_strobe && rsp_index_error, rsp_pixel_zero == 8'd0 && rsp_pixel_one == 8'd0 && rsp_pixel_two == 8'd0 && rsp_pixel_three == 8'd0)

endmodule
